>>> design/mtd_pkg.sv
// Shared types and constants for the multicore task dispatcher.
// No dependencies; every other design file except mtd_ram imports this package.
`default_nettype none
package mtd_pkg;

    localparam int CORE_CNT    = 8;
    localparam int CORE_BITS   = 3;
    localparam int QUEUE_DEPTH = 16;
    localparam int SLOT_BITS   = 4;
    localparam int CNT_BITS    = 5;
    localparam int ADDR_BITS   = CORE_BITS + SLOT_BITS;
    localparam int STORE_DEPTH = CORE_CNT * QUEUE_DEPTH;
    localparam int TAG_BITS    = 16;
    localparam int CFG_ADDR_BITS = 5;

    localparam logic [CNT_BITS-1:0] RUN_SAT = CNT_BITS'(16);
    localparam logic [CNT_BITS-1:0] Q_FULL  = CNT_BITS'(QUEUE_DEPTH);

    typedef logic [CORE_BITS-1:0] core_t;
    typedef logic [CNT_BITS-1:0]  cnt_t;
    typedef logic [TAG_BITS-1:0]  tag_t;

    localparam logic [2:0] CMD_SUBMIT = 3'd0;
    localparam logic [2:0] CMD_FETCH  = 3'd1;
    localparam logic [2:0] CMD_DONE   = 3'd2;
    localparam logic [2:0] CMD_CANCEL = 3'd3;
    localparam logic [2:0] CMD_REBAL  = 3'd4;

    localparam logic [2:0] STS_OK       = 3'd0;
    localparam logic [2:0] STS_FULL     = 3'd1;
    localparam logic [2:0] STS_NO_TASK  = 3'd2;
    localparam logic [2:0] STS_NOT_FND  = 3'd3;
    localparam logic [2:0] STS_NO_MIGR  = 3'd4;

    localparam logic [1:0] MODE_RR    = 2'd0;
    localparam logic [1:0] MODE_LL    = 2'd1;
    localparam logic [1:0] MODE_STEAL = 2'd2;
    localparam logic [1:0] MODE_CORE0 = 2'd3;

    localparam logic [2:0] REG_MODE     = 3'd0;
    localparam logic [2:0] REG_ACTIVE   = 3'd1;
    localparam logic [2:0] REG_OVERLOAD = 3'd2;
    localparam logic [2:0] REG_GAP      = 3'd3;
    localparam logic [2:0] REG_PHYS     = 3'd4;
    localparam logic [2:0] REG_GROUP    = 3'd5;

    typedef enum logic [2:0] {
        OP_SUBMIT,
        OP_FETCH,
        OP_DONE,
        OP_CANCEL,
        OP_REBAL,
        OP_BAD
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_POP_WAIT,
        ST_CAN_ISSUE,
        ST_CAN_CHECK,
        ST_SHIFT_ISSUE,
        ST_SHIFT_WR,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [2:0] cmd;
        tag_t       task_tag;
        core_t      core_sel;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        core_t       target_core;
        core_t       source_core;
        tag_t        task_out;
        logic        was_stolen;
        logic [31:0] total_submitted;
        logic [31:0] total_completed;
    } rsp_t;

    typedef struct packed {
        op_t   op;
        tag_t  tag;
        core_t sel;
    } entry_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  active_cores;
        logic [4:0]  busy_limit;
        logic [4:0]  imbalance_gap;
        logic [23:0] physical_map;
        logic [15:0] group_map;
    } cfg_t;

    function automatic logic [2:0] phys_of(logic [23:0] map, core_t c);
        return 3'(map >> (3 * int'(c)));
    endfunction

    function automatic logic [1:0] group_of(logic [15:0] map, core_t c);
        return 2'(map >> (2 * int'(c)));
    endfunction

endpackage
`default_nettype wire

>>> design/mtd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module mtd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> design/mtd_front.sv
// Front end: takes request transfers, classifies the command and holds
// them in a two-entry queue for the back end. Depends on mtd_pkg.
`default_nettype none
module mtd_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire mtd_pkg::req_t req,
    output logic               ent_valid,
    output mtd_pkg::entry_t    ent,
    input  wire logic          ent_pop
);
    import mtd_pkg::*;

    entry_t     slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    entry_t     cls;

    always_comb
    begin
        cls.tag = req.task_tag;
        cls.sel = req.core_sel;
        unique case (req.cmd)
            CMD_SUBMIT: cls.op = OP_SUBMIT;
            CMD_FETCH:  cls.op = OP_FETCH;
            CMD_DONE:   cls.op = OP_DONE;
            CMD_CANCEL: cls.op = OP_CANCEL;
            CMD_REBAL:  cls.op = OP_REBAL;
            default:    cls.op = OP_BAD;
        endcase
    end

    assign req_ready = (count_reg != 2'd2);
    assign push      = req_valid && req_ready;
    assign ent_valid = (count_reg != 2'd0);
    assign ent       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = ent_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(ent_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cls;
        end
    end
endmodule
`default_nettype wire

>>> design/mtd_back.sv
// Back end: sequencer that scans cores, walks the task store and updates
// queue state, then registers one result. Depends on mtd_pkg, mtd_ram.
`default_nettype none
module mtd_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire mtd_pkg::cfg_t   cfg,
    input  wire logic            ent_valid,
    input  wire mtd_pkg::entry_t ent,
    output logic                 ent_pop,
    output logic                 rsp_valid,
    input  wire logic            rsp_ready,
    output mtd_pkg::rsp_t        rsp
);
    import mtd_pkg::*;

    state_t state_reg, state_next;

    logic [SLOT_BITS-1:0] head_reg [CORE_CNT];
    logic [SLOT_BITS-1:0] head_next [CORE_CNT];
    cnt_t q_reg [CORE_CNT];
    cnt_t q_next [CORE_CNT];
    cnt_t run_reg [CORE_CNT];
    cnt_t run_next [CORE_CNT];
    core_t rr_reg, rr_next;
    logic [31:0] sub_reg, sub_next;
    logic [31:0] comp_reg, comp_next;

    op_t   op_reg, op_next;
    tag_t  tag_reg, tag_next;
    core_t sel_reg, sel_next;
    logic [3:0] idx_reg, idx_next;
    logic [5:0] best_reg, best_next;
    core_t bestc_reg, bestc_next;
    logic  t1f_reg, t1f_next;
    core_t t1c_reg, t1c_next;
    logic  t2f_reg, t2f_next;
    cnt_t  t2m_reg, t2m_next;
    core_t t2c_reg, t2c_next;
    logic  t3f_reg, t3f_next;
    cnt_t  t3m_reg, t3m_next;
    core_t t3c_reg, t3c_next;
    core_t vic_reg, vic_next;
    logic [3:0] ci_reg, ci_next;
    cnt_t  cj_reg, cj_next;
    cnt_t  k_reg, k_next;

    logic [2:0] st_reg, st_next;
    core_t tgt_reg, tgt_next;
    core_t src_reg, src_next;
    tag_t  tout_reg, tout_next;
    logic  stl_reg, stl_next;

    logic rsp_valid_reg;
    rsp_t rsp_reg;
    logic rsp_load;

    logic                 ram_we;
    logic [ADDR_BITS-1:0] ram_waddr, ram_raddr;
    tag_t                 ram_wdata, ram_rdata;

    logic [3:0] n_act;
    core_t      sc, ci_c, rr_c;
    logic       sel_ok, vic_any, move_ok, cnt_ok;
    core_t      vic_pick;
    logic [2:0] myp;
    logic [1:0] myg;
    logic [5:0] load_i;

    function automatic logic [ADDR_BITS-1:0] slot(core_t c, logic [SLOT_BITS-1:0] h,
                                                  cnt_t off);
        return {c, SLOT_BITS'(h + off[SLOT_BITS-1:0])};
    endfunction

    mtd_ram #(.WIDTH(TAG_BITS), .DEPTH(STORE_DEPTH)) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // shared helpers
    always_comb
    begin
        if (cfg.active_cores == 4'd0)
            n_act = 4'd1;
        else if (cfg.active_cores > 4'(CORE_CNT))
            n_act = 4'(CORE_CNT);
        else
            n_act = cfg.active_cores;
        sc     = idx_reg[CORE_BITS-1:0];
        ci_c   = ci_reg[CORE_BITS-1:0];
        rr_c   = ({1'b0, rr_reg} < n_act) ? rr_reg : '0;
        sel_ok = ({1'b0, ent.sel} < n_act);
        myp    = phys_of(cfg.physical_map, sel_reg);
        myg    = group_of(cfg.group_map, sel_reg);
        load_i = {1'b0, q_reg[sc]} + {1'b0, run_reg[sc]};
        vic_any = t1f_reg || t2f_reg || t3f_reg;
        priority if (t1f_reg)
            vic_pick = t1c_reg;
        else if (t2f_reg)
            vic_pick = t2c_reg;
        else
            vic_pick = t3c_reg;
        move_ok = t3f_reg && (t3m_reg > cfg.busy_limit)
                  && ((6'(t3m_reg) - best_reg) > 6'(cfg.imbalance_gap));
        cnt_ok = 1'b1;
        for (int c = 0; c < CORE_CNT; c++)
        begin
            if (q_reg[c] > Q_FULL || run_reg[c] > RUN_SAT)
                cnt_ok = 1'b0;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (ent_valid)
                begin
                    unique case (ent.op)
                        OP_SUBMIT:
                            state_next = (cfg.mode == MODE_LL || cfg.mode == MODE_STEAL)
                                         ? ST_SCAN : ST_DECIDE;
                        OP_FETCH:
                            if (!sel_ok)
                                state_next = ST_OUT;
                            else if (q_reg[ent.sel] != '0)
                                state_next = ST_POP_WAIT;
                            else
                                state_next = ST_SCAN;
                        OP_CANCEL: state_next = ST_CAN_ISSUE;
                        OP_REBAL:  state_next = ST_SCAN;
                        default:   state_next = ST_OUT;
                    endcase
                end
            end
            ST_SCAN:
                if (idx_reg + 4'd1 >= n_act)
                    state_next = ST_DECIDE;
            ST_DECIDE:
            begin
                unique case (op_reg)
                    OP_FETCH: state_next = vic_any ? ST_POP_WAIT : ST_OUT;
                    OP_REBAL: state_next = move_ok ? ST_POP_WAIT : ST_OUT;
                    default:  state_next = ST_OUT;
                endcase
            end
            ST_POP_WAIT: state_next = ST_OUT;
            ST_CAN_ISSUE:
                if (ci_reg >= n_act)
                    state_next = ST_OUT;
                else if (cj_reg < q_reg[ci_c])
                    state_next = ST_CAN_CHECK;
            ST_CAN_CHECK:
                state_next = (ram_rdata == tag_reg) ? ST_SHIFT_ISSUE : ST_CAN_ISSUE;
            ST_SHIFT_ISSUE:
                state_next = (k_reg + 5'd1 < q_reg[ci_c]) ? ST_SHIFT_WR : ST_OUT;
            ST_SHIFT_WR: state_next = ST_SHIFT_ISSUE;
            ST_OUT:
                if (!rsp_valid_reg || rsp_ready)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        head_next = head_reg;
        q_next    = q_reg;
        run_next  = run_reg;
        rr_next   = rr_reg;
        sub_next  = sub_reg;
        comp_next = comp_reg;
        op_next   = op_reg;
        tag_next  = tag_reg;
        sel_next  = sel_reg;
        idx_next  = idx_reg;
        best_next = best_reg;
        bestc_next = bestc_reg;
        t1f_next  = t1f_reg;
        t1c_next  = t1c_reg;
        t2f_next  = t2f_reg;
        t2m_next  = t2m_reg;
        t2c_next  = t2c_reg;
        t3f_next  = t3f_reg;
        t3m_next  = t3m_reg;
        t3c_next  = t3c_reg;
        vic_next  = vic_reg;
        ci_next   = ci_reg;
        cj_next   = cj_reg;
        k_next    = k_reg;
        st_next   = st_reg;
        tgt_next  = tgt_reg;
        src_next  = src_reg;
        tout_next = tout_reg;
        stl_next  = stl_reg;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_raddr = '0;
        ent_pop   = 1'b0;
        rsp_load  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (ent_valid)
                begin
                    ent_pop    = 1'b1;
                    op_next    = ent.op;
                    tag_next   = ent.tag;
                    sel_next   = ent.sel;
                    idx_next   = '0;
                    best_next  = '1;
                    bestc_next = '0;
                    t1f_next   = 1'b0;
                    t2f_next   = 1'b0;
                    t3f_next   = 1'b0;
                    t2m_next   = '0;
                    t3m_next   = '0;
                    ci_next    = '0;
                    cj_next    = '0;
                    st_next    = STS_NO_TASK;
                    tgt_next   = '0;
                    src_next   = '0;
                    tout_next  = '0;
                    stl_next   = 1'b0;
                    unique case (ent.op)
                        OP_SUBMIT:
                            if (cfg.mode == MODE_RR)
                            begin
                                bestc_next = rr_c;
                                rr_next = ({1'b0, rr_c} + 4'd1 >= n_act)
                                          ? '0 : CORE_BITS'(rr_c + 3'd1);
                            end
                        OP_FETCH:
                        begin
                            tgt_next = ent.sel;
                            vic_next = ent.sel;
                            ram_raddr = slot(ent.sel, head_reg[ent.sel], '0);
                        end
                        OP_DONE:
                        begin
                            tgt_next = ent.sel;
                            if (sel_ok && run_reg[ent.sel] != '0)
                            begin
                                run_next[ent.sel] = run_reg[ent.sel] - 5'd1;
                                comp_next = comp_reg + 32'd1;
                                st_next   = STS_OK;
                            end
                        end
                        OP_CANCEL: st_next = STS_NOT_FND;
                        OP_REBAL:  st_next = STS_NO_MIGR;
                        default: ;
                    endcase
                end
            end
            ST_SCAN:
            begin
                idx_next = idx_reg + 4'd1;
                if (idx_reg < n_act)
                begin
                    unique case (op_reg)
                        OP_SUBMIT:
                            if (load_i < best_reg)
                            begin
                                best_next  = load_i;
                                bestc_next = sc;
                            end
                        OP_FETCH:
                        begin
                            if (sc != sel_reg && phys_of(cfg.physical_map, sc) == myp
                                && q_reg[sc] != '0 && !t1f_reg)
                            begin
                                t1f_next = 1'b1;
                                t1c_next = sc;
                            end
                            if (sc != sel_reg && phys_of(cfg.physical_map, sc) != myp
                                && group_of(cfg.group_map, sc) == myg && q_reg[sc] > t2m_reg)
                            begin
                                t2f_next = 1'b1;
                                t2m_next = q_reg[sc];
                                t2c_next = sc;
                            end
                            if (sc != sel_reg && q_reg[sc] > t3m_reg)
                            begin
                                t3f_next = 1'b1;
                                t3m_next = q_reg[sc];
                                t3c_next = sc;
                            end
                        end
                        OP_REBAL:
                        begin
                            if (q_reg[sc] > t3m_reg)
                            begin
                                t3f_next = 1'b1;
                                t3m_next = q_reg[sc];
                                t3c_next = sc;
                            end
                            if (6'(q_reg[sc]) < best_reg)
                            begin
                                best_next  = 6'(q_reg[sc]);
                                bestc_next = sc;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_DECIDE:
            begin
                unique case (op_reg)
                    OP_SUBMIT:
                    begin
                        tgt_next  = bestc_reg;
                        tout_next = tag_reg;
                        if (q_reg[bestc_reg] >= Q_FULL)
                            st_next = STS_FULL;
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = slot(bestc_reg, head_reg[bestc_reg], q_reg[bestc_reg]);
                            ram_wdata = tag_reg;
                            q_next[bestc_reg] = q_reg[bestc_reg] + 5'd1;
                            sub_next  = sub_reg + 32'd1;
                            st_next   = STS_OK;
                        end
                    end
                    OP_FETCH:
                    begin
                        vic_next  = vic_pick;
                        ram_raddr = slot(vic_pick, head_reg[vic_pick], '0);
                    end
                    OP_REBAL:
                    begin
                        vic_next  = t3c_reg;
                        ram_raddr = slot(t3c_reg, head_reg[t3c_reg], '0);
                    end
                    default: ;
                endcase
            end
            ST_POP_WAIT:
            begin
                tout_next = ram_rdata;
                src_next  = vic_reg;
                st_next   = STS_OK;
                head_next[vic_reg] = head_reg[vic_reg] + 4'd1;
                q_next[vic_reg]    = q_reg[vic_reg] - 5'd1;
                if (op_reg == OP_FETCH)
                begin
                    stl_next = (vic_reg != sel_reg);
                    if (run_reg[sel_reg] < RUN_SAT)
                        run_next[sel_reg] = run_reg[sel_reg] + 5'd1;
                end
                else
                begin
                    tgt_next  = bestc_reg;
                    ram_we    = 1'b1;
                    ram_waddr = slot(bestc_reg, head_reg[bestc_reg], q_reg[bestc_reg]);
                    ram_wdata = ram_rdata;
                    q_next[bestc_reg] = q_reg[bestc_reg] + 5'd1;
                end
            end
            ST_CAN_ISSUE:
            begin
                if (ci_reg < n_act)
                begin
                    if (cj_reg >= q_reg[ci_c])
                    begin
                        ci_next = ci_reg + 4'd1;
                        cj_next = '0;
                    end
                    else
                        ram_raddr = slot(ci_c, head_reg[ci_c], cj_reg);
                end
            end
            ST_CAN_CHECK:
            begin
                if (ram_rdata == tag_reg)
                begin
                    k_next    = cj_reg;
                    st_next   = STS_OK;
                    tgt_next  = ci_c;
                    src_next  = ci_c;
                    tout_next = tag_reg;
                end
                else
                    cj_next = cj_reg + 5'd1;
            end
            ST_SHIFT_ISSUE:
            begin
                if (k_reg + 5'd1 < q_reg[ci_c])
                    ram_raddr = slot(ci_c, head_reg[ci_c], k_reg + 5'd1);
                else
                    q_next[ci_c] = q_reg[ci_c] - 5'd1;
            end
            ST_SHIFT_WR:
            begin
                // close the gap left by the cancelled entry
                ram_we    = 1'b1;
                ram_waddr = slot(ci_c, head_reg[ci_c], k_reg);
                ram_wdata = ram_rdata;
                k_next    = k_reg + 5'd1;
            end
            ST_OUT:
                rsp_load = !rsp_valid_reg || rsp_ready;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            for (int c = 0; c < CORE_CNT; c++)
            begin
                head_reg[c] <= '0;
                q_reg[c]    <= '0;
                run_reg[c]  <= '0;
            end
            rr_reg        <= '0;
            sub_reg       <= '0;
            comp_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            q_reg     <= q_next;
            run_reg   <= run_next;
            rr_reg    <= rr_next;
            sub_reg   <= sub_next;
            comp_reg  <= comp_next;
            if (rsp_load)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        tag_reg   <= tag_next;
        sel_reg   <= sel_next;
        idx_reg   <= idx_next;
        best_reg  <= best_next;
        bestc_reg <= bestc_next;
        t1f_reg   <= t1f_next;
        t1c_reg   <= t1c_next;
        t2f_reg   <= t2f_next;
        t2m_reg   <= t2m_next;
        t2c_reg   <= t2c_next;
        t3f_reg   <= t3f_next;
        t3m_reg   <= t3m_next;
        t3c_reg   <= t3c_next;
        vic_reg   <= vic_next;
        ci_reg    <= ci_next;
        cj_reg    <= cj_next;
        k_reg     <= k_next;
        st_reg    <= st_next;
        tgt_reg   <= tgt_next;
        src_reg   <= src_next;
        tout_reg  <= tout_next;
        stl_reg   <= stl_next;
        if (rsp_load)
        begin
            rsp_reg.status          <= st_reg;
            rsp_reg.target_core     <= tgt_reg;
            rsp_reg.source_core     <= src_reg;
            rsp_reg.task_out        <= tout_reg;
            rsp_reg.was_stolen      <= stl_reg;
            rsp_reg.total_submitted <= sub_reg;
            rsp_reg.total_completed <= comp_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n) cnt_ok)
        else $error("queue or running count out of range");
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !ram_we)
        else $error("task store written while idle");
    a_sub_from_decide: assert property (@(posedge clk) disable iff (!rst_n)
        sub_reg != $past(sub_reg) |-> $past(state_reg) == ST_DECIDE)
        else $error("submit total moved outside decide");
    a_pop_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        ent_pop |-> state_reg == ST_IDLE && ent_valid)
        else $error("queue entry taken while busy");
endmodule
`default_nettype wire

>>> design/multicore_task_dispatcher.sv
// Multicore task dispatcher top level: config registers, front, back.
// Depends on mtd_pkg, mtd_front, mtd_back (and mtd_ram through mtd_back).
// The back sequencer handles one item at a time; two more can wait in the queue.
// Reset (async, active low) empties all queues and counters; config takes defaults.
`default_nettype none
module multicore_task_dispatcher (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              req_valid,
    output logic                                   req_ready,
    input  wire mtd_pkg::req_t                     req,
    output logic                                   rsp_valid,
    input  wire logic                              rsp_ready,
    output mtd_pkg::rsp_t                          rsp,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [mtd_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]                       pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);
    import mtd_pkg::*;

    cfg_t       cfg_reg;
    logic       cfg_we;
    logic [2:0] cfg_idx;
    logic       ent_valid, ent_pop;
    entry_t     ent;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[CFG_ADDR_BITS-1:2];
    assign cfg_we  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode          <= 2'd0;
            cfg_reg.active_cores  <= 4'd8;
            cfg_reg.busy_limit    <= 5'd5;
            cfg_reg.imbalance_gap <= 5'd2;
            cfg_reg.physical_map  <= 24'd16434824;
            cfg_reg.group_map     <= 16'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_MODE:     cfg_reg.mode          <= pwdata[1:0];
                REG_ACTIVE:   cfg_reg.active_cores  <= pwdata[3:0];
                REG_OVERLOAD: cfg_reg.busy_limit    <= pwdata[4:0];
                REG_GAP:      cfg_reg.imbalance_gap <= pwdata[4:0];
                REG_PHYS:     cfg_reg.physical_map  <= pwdata[23:0];
                REG_GROUP:    cfg_reg.group_map     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_MODE:     prdata = {30'd0, cfg_reg.mode};
            REG_ACTIVE:   prdata = {28'd0, cfg_reg.active_cores};
            REG_OVERLOAD: prdata = {27'd0, cfg_reg.busy_limit};
            REG_GAP:      prdata = {27'd0, cfg_reg.imbalance_gap};
            REG_PHYS:     prdata = {8'd0, cfg_reg.physical_map};
            REG_GROUP:    prdata = {16'd0, cfg_reg.group_map};
            default:      prdata = 32'd0;
        endcase
    end

    mtd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .ent_valid (ent_valid),
        .ent       (ent),
        .ent_pop   (ent_pop)
    );

    mtd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .ent_valid (ent_valid),
        .ent       (ent),
        .ent_pop   (ent_pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );
endmodule
`default_nettype wire
